[rtl/tet_scaled_jacobian_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the tetrahedron scaled Jacobian unit
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TET_SCALED_JACOBIAN_UNIT_ASSERT_SVH
`define TET_SCALED_JACOBIAN_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TSJ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsj: same-cycle check failed");
`define TSJ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsj: next-cycle check failed");
`else
`define TSJ_ASSERT_IMPLY(label, ante, cons)
`define TSJ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/tsj_pkg.sv]
// ---------------------------------------------------------------------------
// tsj_pkg
// Widths, types and edge/corner tables shared by the scaled Jacobian unit.
// ---------------------------------------------------------------------------
package tsj_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_WIDTH   = FRAC_BITS + 2;

    // edge component, per-component square, squared length
    localparam int EW   = COORD_WIDTH + 1;
    localparam int SQCW = 2 * COORD_WIDTH;
    localparam int SQW  = 2 * COORD_WIDTH + 2;
    // cross product component, Jacobian term, Jacobian
    localparam int CRW  = 2 * EW;
    localparam int JTW  = CRW + EW;
    localparam int JW   = JTW + 2;
    localparam int HW   = (JW + 1) / 2;
    // corner product, search word, root digit count
    localparam int PW   = 3 * SQW;
    localparam int SAW  = 2 * JW + 2 * FRAC_BITS + 4;
    localparam int MW   = FRAC_BITS + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [EW-1:0]          edge_t;
    typedef logic [PW-1:0]                 prod_t;
    typedef logic signed [SAW-1:0]         wide_t;
    typedef logic [MW-1:0]                 frac_t;

    typedef struct packed {
        logic valid;
        logic deg;
        logic neg;
    } tsj_ctl_t;

    localparam logic signed [OUT_WIDTH-1:0] ONE_Q     = OUT_WIDTH'(2 ** FRAC_BITS);
    localparam logic signed [OUT_WIDTH-1:0] NEG_ONE_Q = -ONE_Q;

    // edge i runs from vertex EDGE_TAIL[i] to vertex EDGE_HEAD[i]
    localparam int EDGE_HEAD [6] = '{1, 2, 0, 3, 3, 3};
    localparam int EDGE_TAIL [6] = '{0, 1, 2, 0, 1, 2};
    // edges meeting at each corner, taken from CORNER_A, CORNER_B and CORNER_C
    localparam int CORNER_A [4] = '{0, 0, 1, 3};
    localparam int CORNER_B [4] = '{2, 1, 2, 4};
    localparam int CORNER_C [4] = '{3, 4, 5, 5};

endpackage

[rtl/tsj_geom.sv]
// ---------------------------------------------------------------------------
// tsj_geom
// Eight-stage front end: edges, squared lengths, largest corner product,
// Jacobian sign and squared Jacobian scaled for the root search.
// ---------------------------------------------------------------------------
module tsj_geom (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  tsj_pkg::coord_t    pt [4][3],
    output tsj_pkg::prod_t     p_max,
    output tsj_pkg::wide_t     r_val,
    output tsj_pkg::tsj_ctl_t  ctl
);
    import tsj_pkg::*;

    logic [7:0]                 v_reg;
    edge_t                      e_reg [6][3];
    logic [SQCW-1:0]            sqc_reg [6][3];
    logic signed [CRW-1:0]      xp_reg [6];
    edge_t                      e3_g2_reg [3];
    logic [SQW-1:0]             sq_reg [6];
    logic signed [CRW-1:0]      c_reg [3];
    edge_t                      e3_g3_reg [3];
    logic [2*SQW-1:0]           ab_reg [4];
    logic [SQW-1:0]             sqc3_reg [4];
    logic signed [JTW-1:0]      jt_reg [3];
    logic [2*SQW-1:0]           plo_reg [4];
    logic [2*SQW-1:0]           phi_reg [4];
    logic signed [JW-1:0]       j_reg;
    prod_t                      p_reg [4];
    logic [JW-1:0]              jm_reg;
    logic                       neg_g6_reg;
    prod_t                      pm01_reg;
    prod_t                      pm23_reg;
    logic [2*HW-1:0]            jll_reg;
    logic [2*HW-1:0]            jlh_reg;
    logic [2*HW-1:0]            jhh_reg;
    logic                       neg_g7_reg;
    prod_t                      pmax_reg;
    prod_t                      pmax_next;
    logic                       deg_reg;
    logic                       neg_g8_reg;
    logic [2*JW-1:0]            jsq_reg;
    logic [HW-1:0]              jlo;
    logic [HW-1:0]              jhi;

    // advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    assign jlo       = jm_reg[HW-1:0];
    assign jhi       = HW'(jm_reg[JW-1:HW]);
    assign pmax_next = (pm01_reg > pm23_reg) ? pm01_reg : pm23_reg;

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: edge vectors
            for (int i = 0; i < 6; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e_reg[i][k] <= EW'(pt[EDGE_HEAD[i]][k]) - EW'(pt[EDGE_TAIL[i]][k]);
                end
            end
            // stage 2: component squares and cross product terms
            for (int i = 0; i < 6; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sqc_reg[i][k] <= SQCW'(e_reg[i][k] * e_reg[i][k]);
                end
            end
            xp_reg[0] <= CRW'(e_reg[2][1]) * CRW'(e_reg[0][2]);
            xp_reg[1] <= CRW'(e_reg[2][2]) * CRW'(e_reg[0][1]);
            xp_reg[2] <= CRW'(e_reg[2][2]) * CRW'(e_reg[0][0]);
            xp_reg[3] <= CRW'(e_reg[2][0]) * CRW'(e_reg[0][2]);
            xp_reg[4] <= CRW'(e_reg[2][0]) * CRW'(e_reg[0][1]);
            xp_reg[5] <= CRW'(e_reg[2][1]) * CRW'(e_reg[0][0]);
            for (int k = 0; k < 3; k++)
            begin
                e3_g2_reg[k] <= e_reg[3][k];
            end
            // stage 3: squared lengths and cross product
            for (int i = 0; i < 6; i++)
            begin
                sq_reg[i] <= SQW'(sqc_reg[i][0]) + SQW'(sqc_reg[i][1]) + SQW'(sqc_reg[i][2]);
            end
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k]     <= xp_reg[2*k] - xp_reg[2*k+1];
                e3_g3_reg[k] <= e3_g2_reg[k];
            end
            // stage 4: first corner multiply, Jacobian terms
            for (int j = 0; j < 4; j++)
            begin
                ab_reg[j]   <= (2*SQW)'(sq_reg[CORNER_A[j]]) * (2*SQW)'(sq_reg[CORNER_B[j]]);
                sqc3_reg[j] <= sq_reg[CORNER_C[j]];
            end
            for (int k = 0; k < 3; k++)
            begin
                jt_reg[k] <= JTW'(c_reg[k]) * JTW'(e3_g3_reg[k]);
            end
            // stage 5: split second corner multiply, Jacobian sum
            for (int j = 0; j < 4; j++)
            begin
                plo_reg[j] <= (2*SQW)'(ab_reg[j][SQW-1:0]) * (2*SQW)'(sqc3_reg[j]);
                phi_reg[j] <= (2*SQW)'(ab_reg[j][2*SQW-1:SQW]) * (2*SQW)'(sqc3_reg[j]);
            end
            j_reg <= JW'(jt_reg[0]) + JW'(jt_reg[1]) + JW'(jt_reg[2]);
            // stage 6: join partial products, Jacobian sign and magnitude
            for (int j = 0; j < 4; j++)
            begin
                p_reg[j] <= (PW'(phi_reg[j]) << SQW) + PW'(plo_reg[j]);
            end
            neg_g6_reg <= j_reg[JW-1];
            jm_reg     <= j_reg[JW-1] ? JW'(-j_reg) : JW'(j_reg);
            // stage 7: pairwise maximum, split Jacobian square
            pm01_reg   <= (p_reg[1] > p_reg[0]) ? p_reg[1] : p_reg[0];
            pm23_reg   <= (p_reg[3] > p_reg[2]) ? p_reg[3] : p_reg[2];
            jll_reg    <= (2*HW)'(jlo) * (2*HW)'(jlo);
            jlh_reg    <= (2*HW)'(jlo) * (2*HW)'(jhi);
            jhh_reg    <= (2*HW)'(jhi) * (2*HW)'(jhi);
            neg_g7_reg <= neg_g6_reg;
            // stage 8: largest corner product, degenerate flag, J squared
            pmax_reg   <= pmax_next;
            deg_reg    <= (pmax_next == '0);
            jsq_reg    <= ((2*JW)'(jhh_reg) << (2*HW)) + ((2*JW)'(jlh_reg) << (HW + 1))
                          + (2*JW)'(jll_reg);
            neg_g8_reg <= neg_g7_reg;
        end
    end

    assign p_max     = pmax_reg;
    assign r_val     = wide_t'(SAW'(jsq_reg) << (2 * FRAC_BITS + 3));
    assign ctl.valid = v_reg[7];
    assign ctl.deg   = deg_reg;
    assign ctl.neg   = neg_g8_reg;

endmodule

[rtl/tsj_root.sv]
// ---------------------------------------------------------------------------
// tsj_root
// Digit-by-digit search for the largest m with (2m-1)^2 * P <= R, one
// fraction bit per pipeline stage, using only shifts and adds.
// ---------------------------------------------------------------------------
module tsj_root (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tsj_pkg::prod_t     p_in,
    input  tsj_pkg::wide_t     r_in,
    input  tsj_pkg::tsj_ctl_t  ctl_in,
    output tsj_pkg::frac_t     m_out,
    output tsj_pkg::tsj_ctl_t  ctl_out
);
    import tsj_pkg::*;

    // A = (2m-1)^2 * P and B = (2m-1) * P for the digits settled so far
    frac_t     m_w [MW+1];
    wide_t     a_w [MW+1];
    wide_t     b_w [MW+1];
    wide_t     r_w [MW+1];
    prod_t     p_w [MW+1];
    tsj_ctl_t  c_w [MW+1];

    // start from m = 0, where 2m-1 = -1
    assign m_w[0] = '0;
    assign a_w[0] = wide_t'(SAW'(p_in));
    assign b_w[0] = -wide_t'(SAW'(p_in));
    assign r_w[0] = r_in;
    assign p_w[0] = p_in;
    assign c_w[0] = ctl_in;

    for (genvar s = 0; s < MW; s++)
    begin : g_step
        localparam int BIT = FRAC_BITS - s;

        wide_t     pw;
        wide_t     lhs;
        logic      take;
        frac_t     m_reg;
        wide_t     a_reg;
        wide_t     b_reg;
        wide_t     r_reg;
        prod_t     p_reg;
        tsj_ctl_t  c_reg;

        // try setting this bit; never let m pass one
        always_comb
        begin
            pw   = wide_t'(SAW'(p_w[s]));
            lhs  = a_w[s] + (b_w[s] <<< (BIT + 2)) + (pw <<< (2 * BIT + 2));
            take = (lhs <= r_w[s]) && ((BIT == FRAC_BITS) || !m_w[s][FRAC_BITS]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg <= '0;
            end
            else if (en)
            begin
                c_reg <= c_w[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg <= take ? (m_w[s] | (frac_t'(1) << BIT)) : m_w[s];
                a_reg <= take ? lhs : a_w[s];
                b_reg <= take ? (b_w[s] + (pw <<< (BIT + 1))) : b_w[s];
                r_reg <= r_w[s];
                p_reg <= p_w[s];
            end
        end

        assign m_w[s+1] = m_reg;
        assign a_w[s+1] = a_reg;
        assign b_w[s+1] = b_reg;
        assign r_w[s+1] = r_reg;
        assign p_w[s+1] = p_reg;
        assign c_w[s+1] = c_reg;
    end

    assign m_out   = m_w[MW];
    assign ctl_out = c_w[MW];

endmodule

[rtl/tet_scaled_jacobian_unit.sv]
// ---------------------------------------------------------------------------
// tet_scaled_jacobian_unit
// Scaled Jacobian quality of one tetrahedron per request.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_ready with the four vertices p0..p3 as signed
// grid coordinates. Output channel: out_valid/out_ready with scaled_jacobian
// (signed, 14 fraction bits, within plus or minus one) and degenerate.
// A request is taken on any edge where valid and ready are both high.
// Throughput: one request per cycle while the output is not stalled. The
// pipeline has 8 geometry stages
// (edges, squared lengths, corner products, Jacobian), 15 root search stages
// (one fraction bit per stage), and the output register.
// When every corner product is zero, the result is -1 with degenerate set.
// The whole pipeline advances on one enable: while the output register holds
// a result that the receiver has not taken, in_ready drops and every stage
// holds, so nothing is lost or repeated. Reset clears all valid bits; the
// block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
`include "tet_scaled_jacobian_unit_assert.svh"

module tet_scaled_jacobian_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  tsj_pkg::coord_t                       p0_x,
    input  tsj_pkg::coord_t                       p0_y,
    input  tsj_pkg::coord_t                       p0_z,
    input  tsj_pkg::coord_t                       p1_x,
    input  tsj_pkg::coord_t                       p1_y,
    input  tsj_pkg::coord_t                       p1_z,
    input  tsj_pkg::coord_t                       p2_x,
    input  tsj_pkg::coord_t                       p2_y,
    input  tsj_pkg::coord_t                       p2_z,
    input  tsj_pkg::coord_t                       p3_x,
    input  tsj_pkg::coord_t                       p3_y,
    input  tsj_pkg::coord_t                       p3_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tsj_pkg::OUT_WIDTH-1:0]  scaled_jacobian,
    output logic                                  degenerate
);
    import tsj_pkg::*;

    logic                          en;
    coord_t                        pt [4][3];
    prod_t                         p_max;
    wide_t                         r_val;
    tsj_ctl_t                      ctl_geom;
    frac_t                         m_root;
    tsj_ctl_t                      ctl_root;
    logic                          out_valid_reg;
    logic signed [OUT_WIDTH-1:0]   sj_reg;
    logic signed [OUT_WIDTH-1:0]   sj_next;
    logic                          deg_out_reg;

    // advance everything unless a result waits on a stalled receiver
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign pt[0][0] = p0_x;
    assign pt[0][1] = p0_y;
    assign pt[0][2] = p0_z;
    assign pt[1][0] = p1_x;
    assign pt[1][1] = p1_y;
    assign pt[1][2] = p1_z;
    assign pt[2][0] = p2_x;
    assign pt[2][1] = p2_y;
    assign pt[2][2] = p2_z;
    assign pt[3][0] = p3_x;
    assign pt[3][1] = p3_y;
    assign pt[3][2] = p3_z;

    tsj_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .pt       (pt),
        .p_max    (p_max),
        .r_val    (r_val),
        .ctl      (ctl_geom)
    );

    tsj_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .p_in    (p_max),
        .r_in    (r_val),
        .ctl_in  (ctl_geom),
        .m_out   (m_root),
        .ctl_out (ctl_root)
    );

    // apply sign, force minus one on a degenerate element
    always_comb
    begin
        priority if (ctl_root.deg)
        begin
            sj_next = NEG_ONE_Q;
        end
        else if (ctl_root.neg)
        begin
            sj_next = -OUT_WIDTH'(m_root);
        end
        else
        begin
            sj_next = OUT_WIDTH'(m_root);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_root.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sj_reg      <= sj_next;
            deg_out_reg <= ctl_root.deg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign scaled_jacobian = sj_reg;
    assign degenerate      = deg_out_reg;

    `TSJ_ASSERT_IMPLY(a_deg_is_minus_one, out_valid_reg && deg_out_reg, sj_reg == NEG_ONE_Q)
    `TSJ_ASSERT_IMPLY(a_result_in_range, out_valid_reg, (sj_reg <= ONE_Q) && (sj_reg >= NEG_ONE_Q))
    `TSJ_ASSERT_NEXT(a_root_reaches_out, ctl_root.valid && en, out_valid_reg)

endmodule
